>>> rtl/core/windowed_minimum_baseline_removal_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for windowed minimum baseline removal
// Shared assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MINIMUM_BASELINE_REMOVAL_DEFINES_SVH
`define WINDOWED_MINIMUM_BASELINE_REMOVAL_DEFINES_SVH

// Checked only while the block is out of reset.
`define WMBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define WMBR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/wmbr_pkg.sv
// ----------------------------------------------------------------------------
// wmbr_pkg
// Types and constants shared by the baseline removal modules.
// ----------------------------------------------------------------------------
package wmbr_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int TIME_W         = 40;
    localparam int ITEM_W         = SAMPLE_W + TIME_W;
    localparam int WINDOW_W       = 32;
    localparam int RING_DEPTH_DEF = 128;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [WINDOW_W-1:0]   WINDOW_RESET    = 32'd3600000;
    localparam logic [APB_ADDR_W-1:0] REG_WINDOW_ADDR = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/core/windowed_minimum_baseline_removal.sv
// ----------------------------------------------------------------------------
// windowed_minimum_baseline_removal
// Subtracts the minimum of recent leak samples within a time window.
// ----------------------------------------------------------------------------
// Each item carries a leak sample and its time. The sample is written into a
// ring of the last RING_DEPTH items, then the filled entries are read one per
// cycle through the ring's single read port and the smallest value whose time
// plus window_ms exceeds the new time is kept. The result is the sample minus
// that minimum, clamped at zero, with the sample's time. An item is loaded in
// the idle state, scanned in the scan state and flushed, then waits in the
// done state until the output register is free; the block is ready for the
// next item once the result has entered the output register, even while that
// result still waits to be taken.
module windowed_minimum_baseline_removal #(
    parameter int RING_DEPTH = wmbr_pkg::RING_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wmbr_pkg::ITEM_W-1:0]         s_tdata,   // leak_sample, sample_time
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wmbr_pkg::ITEM_W-1:0]         m_tdata,   // leak_above_baseline, result_time
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wmbr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wmbr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wmbr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    wmbr_pkg::cmd_t                 cmd;
    wmbr_pkg::stat_t                stat;
    logic [wmbr_pkg::WINDOW_W-1:0]  window_ms;
    logic [wmbr_pkg::SAMPLE_W-1:0]  out_leak;
    logic [wmbr_pkg::TIME_W-1:0]    out_time;

    wmbr_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .window_ms (window_ms)
    );

    wmbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wmbr_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_sample (s_tdata[wmbr_pkg::SAMPLE_W-1:0]),
        .in_time   (s_tdata[wmbr_pkg::ITEM_W-1:wmbr_pkg::SAMPLE_W]),
        .window_ms (window_ms),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_leak  (out_leak),
        .out_time  (out_time)
    );

    assign m_tdata = {out_time, out_leak};

endmodule

>>> rtl/core/wmbr_ram.sv
// ----------------------------------------------------------------------------
// wmbr_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module wmbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/wmbr_regs.sv
// ----------------------------------------------------------------------------
// wmbr_regs
// APB register file holding the look-back window length.
// ----------------------------------------------------------------------------
module wmbr_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wmbr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wmbr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wmbr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [wmbr_pkg::WINDOW_W-1:0]       window_ms
);

    logic [wmbr_pkg::WINDOW_W-1:0] window_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == wmbr_pkg::REG_WINDOW_ADDR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= wmbr_pkg::WINDOW_RESET;
        end else if (wr_en) begin
            window_reg <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == wmbr_pkg::REG_WINDOW_ADDR) begin
            prdata = window_reg;
        end
    end

    assign window_ms = window_reg;

endmodule

>>> rtl/core/wmbr_ctrl.sv
// ----------------------------------------------------------------------------
// wmbr_ctrl
// Sequencer that takes an item, scans the ring and hands off the result.
// ----------------------------------------------------------------------------
module wmbr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  wmbr_pkg::stat_t stat,
    output wmbr_pkg::cmd_t  cmd
);

    wmbr_pkg::state_t state_reg;
    wmbr_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wmbr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            wmbr_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = wmbr_pkg::ST_SCAN;
                end
            end
            wmbr_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = wmbr_pkg::ST_FLUSH;
                end
            end
            wmbr_pkg::ST_FLUSH: begin
                state_next = wmbr_pkg::ST_DONE;
            end
            wmbr_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = wmbr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wmbr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/wmbr_datapath.sv
// ----------------------------------------------------------------------------
// wmbr_datapath
// Sample ring, windowed minimum search and output register.
// ----------------------------------------------------------------------------
module wmbr_datapath #(
    parameter int RING_DEPTH = wmbr_pkg::RING_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wmbr_pkg::cmd_t                    cmd,
    output wmbr_pkg::stat_t                   stat,
    input  logic [wmbr_pkg::SAMPLE_W-1:0]     in_sample,
    input  logic [wmbr_pkg::TIME_W-1:0]       in_time,
    input  logic [wmbr_pkg::WINDOW_W-1:0]     window_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [wmbr_pkg::SAMPLE_W-1:0]     out_leak,
    output logic [wmbr_pkg::TIME_W-1:0]       out_time
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    logic [AW-1:0]                  wp_reg;
    logic [CW-1:0]                  fill_reg;
    logic [AW-1:0]                  cnt_reg;
    logic                           rd_pend_reg;
    logic [wmbr_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [wmbr_pkg::TIME_W-1:0]    now_reg;
    logic [wmbr_pkg::SAMPLE_W-1:0]  lowest_reg;
    logic                           out_valid_reg;
    logic [wmbr_pkg::SAMPLE_W-1:0]  out_leak_reg;
    logic [wmbr_pkg::TIME_W-1:0]    out_time_reg;

    logic [wmbr_pkg::ITEM_W-1:0]    rd_data;
    logic [wmbr_pkg::SAMPLE_W-1:0]  rd_value;
    logic [wmbr_pkg::TIME_W-1:0]    rd_time;
    logic [wmbr_pkg::TIME_W:0]      rd_limit;
    logic                           in_window;

    wmbr_ram #(
        .WIDTH (wmbr_pkg::ITEM_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (wp_reg),
        .wdata ({in_time, in_sample}),
        .re    (cmd.scan),
        .raddr (cnt_reg),
        .rdata (rd_data)
    );

    assign rd_value  = rd_data[wmbr_pkg::SAMPLE_W-1:0];
    assign rd_time   = rd_data[wmbr_pkg::ITEM_W-1:wmbr_pkg::SAMPLE_W];
    assign rd_limit  = {1'b0, rd_time} + (wmbr_pkg::TIME_W+1)'(window_ms);
    assign in_window = rd_limit > {1'b0, now_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            fill_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.scan;
            if (cmd.load) begin
                if (wp_reg == AW'(RING_DEPTH - 1)) begin
                    wp_reg <= '0;
                end else begin
                    wp_reg <= wp_reg + AW'(1);
                end
                if (fill_reg != CW'(RING_DEPTH)) begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= in_sample;
            now_reg    <= in_time;
            lowest_reg <= in_sample;
            cnt_reg    <= '0;
        end else begin
            if (cmd.scan) begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            if (rd_pend_reg && in_window && (rd_value < lowest_reg)) begin
                lowest_reg <= rd_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_leak_reg <= (sample_reg > lowest_reg) ? (sample_reg - lowest_reg) : '0;
            out_time_reg <= now_reg;
        end
    end

    assign stat.scan_last = (CW'(cnt_reg) == (fill_reg - CW'(1)));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_leak  = out_leak_reg;
    assign out_time  = out_time_reg;

endmodule

>>> rtl/core/wmbr_checker.sv
// ----------------------------------------------------------------------------
// wmbr_checker
// Port-level checks on the baseline removal block, bound to its top level.
// ----------------------------------------------------------------------------
`include "windowed_minimum_baseline_removal_defines.svh"

module wmbr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [wmbr_pkg::ITEM_W-1:0] m_tdata
);

    // A stalled result must hold its value.
    `WMBR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // The block works on one item at a time, so it stops taking items after an accept.
    `WMBR_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "item accepted while busy")

    // Reset empties the output register.
    `WMBR_ASSERT_ALWAYS(a_reset_out, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind windowed_minimum_baseline_removal wmbr_checker u_wmbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/windowed_minimum_baseline_removal_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_minimum_baseline_removal_tb
// Self-checking bench for the windowed minimum baseline removal block.
// Leak samples with timestamps are streamed in under several window settings.
// A local ring model predicts each baseline-removed result, and every
// returned item is compared field by field. The window register is written
// and read back over the APB port while the block is idle.
// ----------------------------------------------------------------------------
module windowed_minimum_baseline_removal_tb;

    typedef logic [wmbr_pkg::SAMPLE_W-1:0]   sample_t;
    typedef logic [wmbr_pkg::TIME_W-1:0]     stamp_t;
    typedef logic [wmbr_pkg::TIME_W:0]       reach_t;
    typedef logic [wmbr_pkg::WINDOW_W-1:0]   window_t;
    typedef logic [wmbr_pkg::APB_DATA_W-1:0] apb_data_t;

    localparam int              DEPTH        = wmbr_pkg::RING_DEPTH_DEF;
    localparam int              HALF_PERIOD  = 4;
    localparam int              RANDOM_ITEMS = 140;
    localparam int              EXP_SLOTS    = 64;
    localparam longint          CYCLE_LIMIT  = 600000;
    localparam stamp_t          TIME_MAX     = '1;
    localparam window_t         WINDOW_MAX   = '1;

    typedef struct packed {
        stamp_t  stamp;
        sample_t leak;
    } leak_result_t;

    logic                                aclk     = 1'b0;
    logic                                aresetn  = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [wmbr_pkg::ITEM_W-1:0]         s_tdata  = '0;   // leak_sample, sample_time
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [wmbr_pkg::ITEM_W-1:0]         m_tdata;         // leak_above_baseline, result_time
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [wmbr_pkg::APB_ADDR_W-1:0]     paddr    = '0;
    apb_data_t                           pwdata   = '0;
    apb_data_t                           prdata;
    logic                                pready;

    sample_t                hist_value [DEPTH];
    stamp_t                 hist_stamp [DEPTH];
    int unsigned            hist_next = 0;
    int unsigned            hist_fill = 0;
    window_t                window_now = wmbr_pkg::WINDOW_RESET;
    stamp_t                 stream_clock = '0;
    leak_result_t           expected_results [EXP_SLOTS];
    int unsigned            exp_head = 0;
    int unsigned            exp_tail = 0;
    int unsigned            mismatches = 0;
    int unsigned            items_sent = 0;
    int unsigned            results_checked = 0;
    int unsigned            window_writes = 0;
    longint unsigned        cycles = 0;
    bit                     steady_flow = 1'b0;

    windowed_minimum_baseline_removal #(
        .RING_DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(99) >= 24);
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    // The new sample enters the ring first, so it always takes part in the
    // minimum. An entry counts when its stamp plus the window exceeds the
    // new stamp, evaluated one bit wider so that nothing wraps.
    function automatic leak_result_t predict_baseline(input sample_t sample,
                                                      input stamp_t stamp);
        sample_t      lowest;
        reach_t       reach;
        leak_result_t res;
        int unsigned  k;
        hist_value[hist_next] = sample;
        hist_stamp[hist_next] = stamp;
        hist_next = (hist_next + 1) % DEPTH;
        if (hist_fill < DEPTH) begin
            hist_fill++;
        end
        lowest = sample;
        for (k = 0; k < hist_fill; k++) begin
            reach = {1'b0, hist_stamp[k]} + reach_t'(window_now);
            if (reach > {1'b0, stamp} && hist_value[k] < lowest) begin
                lowest = hist_value[k];
            end
        end
        res.leak  = (sample > lowest) ? sample - lowest : '0;
        res.stamp = stamp;
        return res;
    endfunction

    always @(posedge aclk) begin : result_check
        leak_result_t got;
        leak_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (exp_tail == exp_head) begin
                report_mismatch($sformatf("unexpected item leak=%0d stamp=%0d",
                                          got.leak, got.stamp));
            end else begin
                want = expected_results[exp_head % EXP_SLOTS];
                exp_head++;
                results_checked++;
                if (got.leak !== want.leak) begin
                    report_mismatch($sformatf("leak_above_baseline %0d, expected %0d (stamp %0d)",
                                              got.leak, want.leak, want.stamp));
                end
                if (got.stamp !== want.stamp) begin
                    report_mismatch($sformatf("result_time %0d, expected %0d",
                                              got.stamp, want.stamp));
                end
            end
        end
    end

    task automatic send_item(input sample_t sample, input stamp_t stamp);
        @(negedge aclk);
        while (!steady_flow && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, sample};
        do @(posedge aclk); while (!s_tready);
        expected_results[exp_tail % EXP_SLOTS] = predict_baseline(sample, stamp);
        exp_tail++;
        items_sent++;
    endtask

    task automatic release_sender();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        release_sender();
        while (exp_tail != exp_head) begin
            @(posedge aclk);
        end
        repeat (DEPTH + 8) @(posedge aclk);
    endtask

    task automatic apb_access(input logic write, input apb_data_t wdata,
                              output apb_data_t rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= wmbr_pkg::REG_WINDOW_ADDR;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_window(input window_t value);
        apb_data_t readback;
        apb_access(1'b1, value, readback);
        window_now = value;
        window_writes++;
        apb_access(1'b0, '0, readback);
        if (readback !== value) begin
            report_mismatch($sformatf("window_ms reads %0d, expected %0d", readback, value));
        end
    endtask

    task automatic run_random_items(input int count);
        sample_t base_level;
        sample_t sample;
        base_level = sample_t'($urandom);
        repeat (count) begin
            case ($urandom_range(19))
                0: stream_clock = stamp_t'({$urandom, $urandom});
                1: ;
                default: stream_clock = stream_clock
                                        + stamp_t'($urandom_range((window_now >> 5) + 2));
            endcase
            case ($urandom_range(9))
                0, 1: sample = sample_t'($urandom);
                2: sample = $urandom_range(1) ? '1 : '0;
                default: sample = base_level + sample_t'($urandom_range(255));
            endcase
            send_item(sample, stream_clock);
        end
    endtask

    task automatic test_register_access();
        apb_data_t readback;
        apb_access(1'b0, '0, readback);
        if (readback !== wmbr_pkg::WINDOW_RESET) begin
            report_mismatch($sformatf("window_ms after reset reads %0d", readback));
        end
    endtask

    task automatic test_directed_cases();
        send_item(16'd1000, 40'd0);
        send_item(16'd500, 40'd10);
        send_item(16'd2000, 40'd20);
        send_item(16'hFFFF, 40'd3600000);
        send_item(16'd0, 40'd3600010);
        send_item(16'd7, 40'd3600011);
        send_item(16'hFFFF, 40'd3600009);
        wait_drained();
        set_window(32'd1);
        send_item(16'd100, 40'd3600011);
        send_item(16'd100, 40'd3600011);
        send_item(16'd50, 40'd100);
        send_item(16'hFFFF, TIME_MAX);
        send_item(16'd1, TIME_MAX);
        send_item(16'd3, TIME_MAX);
        send_item(16'd0, TIME_MAX - 1);
        wait_drained();
        set_window(WINDOW_MAX);
        send_item(16'd9, TIME_MAX);
        send_item(16'd10, 40'd0);
        send_item(16'hFFFF, 40'h00FFFFFFFF);
        send_item(16'h8000, 40'h8000000000);
        send_item(16'h5555, 40'h5555555555);
        send_item(16'hAAAA, 40'hAAAAAAAAAA);
        wait_drained();
    endtask

    task automatic test_random_windows();
        window_t settings [5];
        int p;
        settings[0] = 32'd1;
        settings[1] = wmbr_pkg::WINDOW_RESET;
        settings[2] = $urandom_range(5000, 2);
        settings[3] = $urandom | 32'd1;
        settings[4] = WINDOW_MAX;
        for (p = 0; p < 5; p++) begin
            set_window(settings[p]);
            stream_clock = stamp_t'($urandom);
            steady_flow = (p == 1);
            run_random_items(RANDOM_ITEMS);
            wait_drained();
            steady_flow = 1'b0;
        end
    endtask

    // The sender stops after each burst until every result is back.
    task automatic test_burst_drain();
        set_window(32'd500);
        repeat (5) begin
            run_random_items(10);
            wait_drained();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_register_access();
        test_directed_cases();
        test_random_windows();
        test_burst_drain();
        wait_drained();
        $display("Sent %0d items and checked %0d results over %0d window settings,",
                 items_sent, results_checked, window_writes);
        $display("from a one-millisecond window to the widest, with ring wrap and stamp jumps.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches found.", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
